// File: sv/bdq_pkg.sv
// Shared types, sizes and helpers for the bounded deque with search.
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CNT_FW = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_REM_FRONT = 2'd2,
    OP_SEARCH    = 2'd3
  } op_e;

  typedef struct packed {
    logic              ok;
    logic [CNT_FW-1:0] count;
    logic              empty_res;
  } bdq_res_t;

  typedef struct packed {
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    logic [AW-1:0]            raddr;
  } bdq_mem_req_t;

  function automatic bdq_res_t make_res(logic ok, logic [CW-1:0] cnt);
    bdq_res_t r;
    r.ok        = ok;
    r.count     = CNT_FW'(cnt);
    r.empty_res = (cnt == '0);
    return r;
  endfunction

endpackage

// File: sv/bdq_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface bdq_req_if import bdq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*;;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [CNT_FW-1:0] count;
  logic              empty_res;

  modport source (output valid, output ok, output count, output empty_res, input ready);
  modport sink   (input valid, input ok, input count, input empty_res, output ready);
endinterface

// File: sv/bounded_deque_with_search.sv
// Top level: bounded deque of signed words with front/back insert,
// front remove and value search.
//
// Requests arrive on req (op, value) with valid/ready; each request yields
// exactly one item on rsp (ok, count, empty_res), in request order.
// Entries live in a DEPTH-word synchronous RAM (one write, one read port).
// Inserts and removes take effect in the controller; their result is
// registered there and then in the output register, and they sustain one
// item per cycle while rsp does not stall. A search reads the stored
// entries one entry per cycle through the single RAM read port and stops at
// the first match or after the last entry, taking no new request meanwhile;
// its result is registered the same way. A search on an empty deque does no
// walk and answers with ok low and empty_res high.
// Reset clears the front pointer and the count; RAM contents are not
// cleared and are never read before being written.
// When rsp stalls, one result is held in the output register and one more
// in the controller, so one further request is taken before req.ready drops.
`timescale 1ns / 1ps
module bounded_deque_with_search import bdq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_req_if.sink   req,
  bdq_rsp_if.source rsp
);

  bdq_mem_req_t             mem_req;
  logic signed [DATA_W-1:0] rdata;
  logic                     res_valid;
  logic                     res_take;
  bdq_res_t                 res;

  bdq_store u_store (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (rdata)
  );

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .mem_o       (mem_req),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  bdq_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_take_o  (res_take),
    .rsp         (rsp)
  );

endmodule

// File: sv/bdq_store.sv
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module bdq_store import bdq_pkg::*; (
  input  logic                     clk_i,
  input  bdq_mem_req_t             mem_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.waddr] <= mem_i.wdata;
    end
    if (mem_i.re) begin
      rdata_o <= mem_q[mem_i.raddr];
    end
  end

endmodule

// File: sv/bdq_ctrl.sv
// Pointer bookkeeping, request decode and the search walk over the store.
`timescale 1ns / 1ps
module bdq_ctrl import bdq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bdq_req_if.sink                  req,
  output bdq_mem_req_t             mem_o,
  input  logic signed [DATA_W-1:0] rdata_i,
  output logic                     res_valid_o,
  output bdq_res_t                 res_o,
  input  logic                     res_take_i
);

  typedef enum logic {S_IDLE, S_SEARCH} state_e;

  state_e                   state_q;
  logic [AW-1:0]            front_q, front_d;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            rp_q;
  logic [CW-1:0]            remain_q;
  logic                     rvalid_q;
  logic signed [DATA_W-1:0] key_q;
  logic                     res_valid_q;
  bdq_res_t                 res_q;

  op_e           op;
  logic          accept, full, empty, imm_ok, hit, search_done;
  logic [AW-1:0] front_dec, front_inc, rp_next, back_pos;
  logic [AW:0]   back_sum;

  assign op     = op_e'(req.op);
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign req.ready = (state_q == S_IDLE) && (!res_valid_q || res_take_i);
  assign accept = req.valid && req.ready;

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign rp_next   = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
  // back slot = front + count, wrapped once (count < DEPTH when inserting)
  assign back_sum  = {1'b0, front_q} + (AW + 1)'(count_q);
  assign back_pos  = (back_sum >= (AW + 1)'(DEPTH)) ? AW'(back_sum - (AW + 1)'(DEPTH))
                                                   : AW'(back_sum);

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    imm_ok  = 1'b0;
    case (op)
      OP_INS_FRONT: begin
        if (!full) begin
          front_d = front_dec;
          count_d = count_q + 1'b1;
          imm_ok  = 1'b1;
        end
      end
      OP_INS_BACK: begin
        if (!full) begin
          count_d = count_q + 1'b1;
          imm_ok  = 1'b1;
        end
      end
      OP_REM_FRONT: begin
        if (!empty) begin
          front_d = front_inc;
          count_d = count_q - 1'b1;
          imm_ok  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_o.we    = accept && !full && ((op == OP_INS_FRONT) || (op == OP_INS_BACK));
    mem_o.waddr = (op == OP_INS_FRONT) ? front_dec : back_pos;
    mem_o.wdata = req.value;
    mem_o.re    = (state_q == S_SEARCH) && (remain_q != '0);
    mem_o.raddr = rp_q;
  end

  assign hit         = rvalid_q && (rdata_i == key_q);
  // done on a match or once the last issued read has been compared
  assign search_done = (state_q == S_SEARCH) && (hit || (rvalid_q && remain_q == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      rp_q        <= '0;
      remain_q    <= '0;
      rvalid_q    <= 1'b0;
      key_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      rvalid_q <= mem_o.re;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_SEARCH && !empty) begin
              state_q     <= S_SEARCH;
              key_q       <= req.value;
              rp_q        <= front_q;
              remain_q    <= count_q;
              res_valid_q <= 1'b0;
            end else begin
              front_q     <= front_d;
              count_q     <= count_d;
              res_valid_q <= 1'b1;
              res_q       <= make_res(imm_ok, count_d);
            end
          end else if (res_take_i) begin
            res_valid_q <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (search_done) begin
            state_q     <= S_IDLE;
            remain_q    <= '0;
            res_valid_q <= 1'b1;
            res_q       <= make_res(hit, count_q);
          end else if (mem_o.re) begin
            rp_q     <= rp_next;
            remain_q <= remain_q - 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q) && $stable(front_q))
    else $error("pointers moved without an accepted item");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> remain_q <= count_q && !res_valid_q && !mem_o.we)
    else $error("search walk out of bounds or overlapping a result");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_take_i |=> res_valid_q && $stable(res_q))
    else $error("pending result lost before hand-off");

endmodule

// File: sv/bdq_out.sv
// Output register stage driving the response channel.
`timescale 1ns / 1ps
module bdq_out import bdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  input  bdq_res_t res_i,
  output logic     res_take_o,
  bdq_rsp_if.source rsp
);

  logic     valid_q;
  bdq_res_t data_q;

  assign res_take_o = res_valid_i && (!valid_q || rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= '0;
    end else begin
      if (res_take_o) begin
        valid_q <= 1'b1;
        data_q  <= res_i;
      end else if (rsp.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign rsp.valid     = valid_q;
  assign rsp.ok        = data_q.ok;
  assign rsp.count     = data_q.count;
  assign rsp.empty_res = data_q.empty_res;

endmodule
